/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module g2pd_check.
// Needs a clock and an active-low reset in scope at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/g2pd_pkg.sv */
// Shared types and constants of the packet deframer.
// No dependencies.
`default_nettype none

package g2pd_pkg;

  localparam logic [7:0]  CTRL_LENLEN_MASK = 8'hC0;
  localparam logic [7:0]  CTRL_TYPE_MASK   = 8'h38;
  localparam logic [7:0]  CTRL_FLAGS_MASK  = 8'h07;
  localparam logic [2:0]  FLAG_BIG_ENDIAN  = 3'b010;
  localparam logic [23:0] MAX_LEN_RESET    = 24'd65535;

  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 2;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LEN  = 2'd1,
    PH_TYPE = 2'd2,
    PH_PAY  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_PAD  = 3'd0,
    ROLE_CTRL = 3'd1,
    ROLE_LEN  = 3'd2,
    ROLE_TYPE = 3'd3,
    ROLE_PAY  = 3'd4,
    ROLE_HALT = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENLEN = 2'd1,
    ERR_LIMIT  = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    role_t       byte_role;
    logic [2:0]  packet_flags;
    logic [3:0]  type_byte_count;
    logic [23:0] payload_length;
    logic        packet_end;
    err_t        error_code;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/g2pd_parse.sv */
// Framing state machine: tags one byte per request with its role.
// Depends on g2pd_pkg.
`default_nettype none

module g2pd_parse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [23:0]     cfg_wr_data,
  input  wire logic            req_valid,
  input  wire logic [7:0]      req_byte,
  output g2pd_pkg::res_t       res
);

  logic [23:0]      max_len_r;
  g2pd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       len_left_r, len_left_nxt;
  logic [3:0]       type_left_r, type_left_nxt;
  logic [23:0]      pay_left_r, pay_left_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [1:0]       len_idx_r, len_idx_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic [3:0]       type_cnt_r, type_cnt_nxt;
  logic             halted_r, halted_nxt;

  logic [1:0]  lenlen;
  logic [1:0]  len_left_dec;
  logic [3:0]  type_left_dec;
  logic [23:0] pay_left_dec;
  logic [23:0] acc_upd;
  logic        over_limit;

  assign lenlen        = 2'((req_byte & g2pd_pkg::CTRL_LENLEN_MASK) >> 6);
  assign len_left_dec  = len_left_r - 2'd1;
  assign type_left_dec = type_left_r - 4'd1;
  assign pay_left_dec  = pay_left_r - 24'd1;

  always_comb begin
    if ((flags_r & g2pd_pkg::FLAG_BIG_ENDIAN) != 3'd0) begin
      acc_upd = {acc_r[15:0], req_byte};
    end else begin
      case (len_idx_r)
        2'd0:    acc_upd = {acc_r[23:8], acc_r[7:0] | req_byte};
        2'd1:    acc_upd = {acc_r[23:16], acc_r[15:8] | req_byte, acc_r[7:0]};
        2'd2:    acc_upd = {acc_r[23:16] | req_byte, acc_r[15:0]};
        default: acc_upd = acc_r;
      endcase
    end
  end

  assign over_limit = (acc_upd >= max_len_r);

  always_comb begin
    phase_nxt = phase_r;
    if (!halted_r) begin
      case (phase_r)
        g2pd_pkg::PH_CTRL: begin
          if (req_byte != 8'd0 && lenlen != 2'd0) phase_nxt = g2pd_pkg::PH_LEN;
        end
        g2pd_pkg::PH_LEN: begin
          if (len_left_dec == 2'd0 && !over_limit) phase_nxt = g2pd_pkg::PH_TYPE;
        end
        g2pd_pkg::PH_TYPE: begin
          if (type_left_dec == 4'd0) begin
            phase_nxt = (pay_left_r == 24'd0) ? g2pd_pkg::PH_CTRL : g2pd_pkg::PH_PAY;
          end
        end
        g2pd_pkg::PH_PAY: begin
          if (pay_left_dec == 24'd0) phase_nxt = g2pd_pkg::PH_CTRL;
        end
        default: phase_nxt = g2pd_pkg::PH_CTRL;
      endcase
    end
  end

  always_comb begin
    len_left_nxt  = len_left_r;
    type_left_nxt = type_left_r;
    pay_left_nxt  = pay_left_r;
    acc_nxt       = acc_r;
    len_idx_nxt   = len_idx_r;
    flags_nxt     = flags_r;
    type_cnt_nxt  = type_cnt_r;
    halted_nxt    = halted_r;
    res.byte_role  = g2pd_pkg::ROLE_HALT;
    res.packet_end = 1'b0;
    res.error_code = g2pd_pkg::ERR_NONE;
    if (!halted_r) begin
      case (phase_r)
        g2pd_pkg::PH_LEN: begin
          res.byte_role = g2pd_pkg::ROLE_LEN;
          acc_nxt       = acc_upd;
          len_idx_nxt   = len_idx_r + 2'd1;
          len_left_nxt  = len_left_dec;
          if (len_left_dec == 2'd0) begin
            if (over_limit) begin
              res.error_code = g2pd_pkg::ERR_LIMIT;
              halted_nxt     = 1'b1;
            end else begin
              pay_left_nxt  = acc_upd;
              type_left_nxt = type_cnt_r;
            end
          end
        end
        g2pd_pkg::PH_TYPE: begin
          res.byte_role = g2pd_pkg::ROLE_TYPE;
          type_left_nxt = type_left_dec;
          if (type_left_dec == 4'd0 && pay_left_r == 24'd0) res.packet_end = 1'b1;
        end
        g2pd_pkg::PH_PAY: begin
          res.byte_role = g2pd_pkg::ROLE_PAY;
          pay_left_nxt  = pay_left_dec;
          if (pay_left_dec == 24'd0) res.packet_end = 1'b1;
        end
        default: begin
          if (req_byte == 8'd0) begin
            res.byte_role = g2pd_pkg::ROLE_PAD;
          end else begin
            res.byte_role = g2pd_pkg::ROLE_CTRL;
            flags_nxt     = 3'(req_byte & g2pd_pkg::CTRL_FLAGS_MASK);
            type_cnt_nxt  = 4'((req_byte & g2pd_pkg::CTRL_TYPE_MASK) >> 3) + 4'd1;
            acc_nxt       = 24'd0;
            len_idx_nxt   = 2'd0;
            if (lenlen == 2'd0) begin
              res.error_code = g2pd_pkg::ERR_LENLEN;
              halted_nxt     = 1'b1;
            end else begin
              len_left_nxt = lenlen;
            end
          end
        end
      endcase
    end
    res.byte_out        = req_byte;
    res.packet_flags    = flags_nxt;
    res.type_byte_count = type_cnt_nxt;
    res.payload_length  = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= g2pd_pkg::MAX_LEN_RESET;
      phase_r     <= g2pd_pkg::PH_CTRL;
      len_left_r  <= 2'd0;
      type_left_r <= 4'd0;
      pay_left_r  <= 24'd0;
      acc_r       <= 24'd0;
      len_idx_r   <= 2'd0;
      flags_r     <= 3'd0;
      type_cnt_r  <= 4'd1;
      halted_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      if (req_valid) begin
        phase_r     <= phase_nxt;
        len_left_r  <= len_left_nxt;
        type_left_r <= type_left_nxt;
        pay_left_r  <= pay_left_nxt;
        acc_r       <= acc_nxt;
        len_idx_r   <= len_idx_nxt;
        flags_r     <= flags_nxt;
        type_cnt_r  <= type_cnt_nxt;
        halted_r    <= halted_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/g2pd_rbuf.sv */
// Three-entry result buffer between the parser and the output channel.
// Depends on g2pd_pkg.
`default_nettype none

module g2pd_rbuf (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire g2pd_pkg::res_t           push_data,
  input  wire logic                     pop,
  output logic                          not_empty,
  output logic [g2pd_pkg::CNT_W-1:0]    count,
  output g2pd_pkg::res_t                head
);

  localparam logic [g2pd_pkg::PTR_W-1:0] PTR_LAST = g2pd_pkg::PTR_W'(g2pd_pkg::FIFO_DEPTH - 1);

  g2pd_pkg::res_t                entry_r [g2pd_pkg::FIFO_DEPTH];
  logic [g2pd_pkg::PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [g2pd_pkg::PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [g2pd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + g2pd_pkg::PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + g2pd_pkg::PTR_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + g2pd_pkg::CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - g2pd_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;
  assign head      = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/core/g2_packet_deframer.sv */
// Packet deframer: one stream byte per request in, one tagged byte per request out.
// Takes one byte every clock while the output keeps up. A byte is held in the input
// register, is tagged by the framing state machine and lands in a three-entry result
// buffer, from whose head it shows on out_valid.
// in_stall is computed from registered occupancy only, never from out_stall. After a
// framing error every later byte comes out tagged as discarded until reset.
// Depends on g2pd_pkg, g2pd_parse, g2pd_rbuf.
`default_nettype none

module g2_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_out,
  output logic [2:0]       out_byte_role,
  output logic [2:0]       out_packet_flags,
  output logic [3:0]       out_type_byte_count,
  output logic [23:0]      out_payload_length,
  output logic             out_packet_end,
  output logic [1:0]       out_error_code
);

  logic                          s1_valid_r;
  logic [7:0]                    s1_byte_r;
  logic                          in_take;
  logic                          out_take;
  logic [g2pd_pkg::CNT_W-1:0]    buf_cnt;
  logic [g2pd_pkg::CNT_W:0]      occupancy;
  g2pd_pkg::res_t                parse_res;
  g2pd_pkg::res_t                head;

  assign occupancy = {1'b0, buf_cnt} + {{g2pd_pkg::CNT_W{1'b0}}, s1_valid_r};
  assign in_stall  = (occupancy >= (g2pd_pkg::CNT_W + 1)'(g2pd_pkg::FIFO_DEPTH));
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_stream_byte;
  end

  g2pd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (s1_valid_r),
    .req_byte    (s1_byte_r),
    .res         (parse_res)
  );

  g2pd_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (parse_res),
    .pop       (out_take),
    .not_empty (out_valid),
    .count     (buf_cnt),
    .head      (head)
  );

  assign out_byte_out        = head.byte_out;
  assign out_byte_role       = head.byte_role;
  assign out_packet_flags    = head.packet_flags;
  assign out_type_byte_count = head.type_byte_count;
  assign out_payload_length  = head.payload_length;
  assign out_packet_end      = head.packet_end;
  assign out_error_code      = head.error_code;

endmodule

`default_nettype wire

/* rtl/core/g2pd_check.sv */
// Port-level checks of the packet deframer, attached by bind.
// Depends on g2pd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module g2pd_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte_out,
  input wire logic [2:0]  out_byte_role,
  input wire logic        out_packet_end,
  input wire logic [1:0]  out_error_code
);

  logic out_take;
  logic role_halt;
  logic err_raised;
  logic halt_seen;
  logic err_ok;
  logic quiet_role;
  logic quiet_ok;

  assign out_take   = out_valid && !out_stall;
  assign role_halt  = (out_byte_role == g2pd_pkg::ROLE_HALT);
  assign err_raised = (out_error_code != g2pd_pkg::ERR_NONE);
  assign halt_seen  = role_halt || err_raised;
  assign err_ok     = ((out_error_code == g2pd_pkg::ERR_LENLEN) &&
                       (out_byte_role == g2pd_pkg::ROLE_CTRL)) ||
                      ((out_error_code == g2pd_pkg::ERR_LIMIT) &&
                       (out_byte_role == g2pd_pkg::ROLE_LEN));
  assign quiet_role = role_halt || (out_byte_role == g2pd_pkg::ROLE_PAD);
  assign quiet_ok   = !out_packet_end && !err_raised;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte_out))
  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_take && halt_seen, !out_valid || role_halt)
  `ASSERT_NOW(a_err_role, clk, rst_n, out_valid && err_raised, err_ok && !out_packet_end)
  `ASSERT_NOW(a_quiet_role, clk, rst_n, out_valid && quiet_role, quiet_ok)

endmodule

bind g2_packet_deframer g2pd_check u_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte_out   (out_byte_out),
  .out_byte_role  (out_byte_role),
  .out_packet_end (out_packet_end),
  .out_error_code (out_error_code)
);

`default_nettype wire

/* tb/tb_g2_packet_deframer.sv */
// Self-checking testbench for g2_packet_deframer: tags every stream byte with its
// packet role and compares each tagged byte with a built-in deframing predictor.
// Depends on g2pd_pkg and the g2_packet_deframer RTL only.
`timescale 1ns / 100ps

module tb_g2_packet_deframer;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    KILL_LENLEN,
    KILL_MAX_LEN,
    KILL_ZERO_LIMIT
  } fatal_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte_out;
  logic [2:0]  out_byte_role;
  logic [2:0]  out_packet_flags;
  logic [3:0]  out_type_byte_count;
  logic [23:0] out_payload_length;
  logic        out_packet_end;
  logic [1:0]  out_error_code;

  // deframer prediction state
  g2pd_pkg::phase_t fr_phase;
  logic [1:0]  fr_len_left;
  logic [1:0]  fr_len_idx;
  logic [3:0]  fr_type_left;
  logic [3:0]  fr_held_count;
  logic [23:0] fr_pay_left;
  logic [23:0] fr_len_acc;
  logic [23:0] fr_limit;
  logic [2:0]  fr_held_flags;
  logic        fr_halted;

  g2pd_pkg::res_t pending_tags[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int unsigned sent_items = 0;
  int          burst_left = 0;
  int          stall_hold = 0;
  logic [1:0]  stall_mode = 2'd0;

  g2_packet_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_out       (out_byte_out),
    .out_byte_role      (out_byte_role),
    .out_packet_flags   (out_packet_flags),
    .out_type_byte_count(out_type_byte_count),
    .out_payload_length (out_payload_length),
    .out_packet_end     (out_packet_end),
    .out_error_code     (out_error_code)
  );

  always #10 clk = ~clk;

  task automatic reset_deframer_state();
    fr_phase      = g2pd_pkg::PH_CTRL;
    fr_len_left   = '0;
    fr_len_idx    = '0;
    fr_type_left  = '0;
    fr_pay_left   = '0;
    fr_len_acc    = '0;
    fr_held_flags = '0;
    fr_held_count = 4'd1;
    fr_halted     = 1'b0;
    fr_limit      = g2pd_pkg::MAX_LEN_RESET;
  endtask

  function automatic g2pd_pkg::res_t deframe_byte(input logic [7:0] b);
    g2pd_pkg::res_t r;
    r.byte_out   = b;
    r.byte_role  = g2pd_pkg::ROLE_PAD;
    r.packet_end = 1'b0;
    r.error_code = g2pd_pkg::ERR_NONE;
    if (fr_halted) begin
      r.byte_role = g2pd_pkg::ROLE_HALT;
    end else begin
      case (fr_phase)
        g2pd_pkg::PH_LEN: begin
          r.byte_role = g2pd_pkg::ROLE_LEN;
          if ((fr_held_flags & g2pd_pkg::FLAG_BIG_ENDIAN) != 0) begin
            fr_len_acc = {fr_len_acc[15:0], b};
          end else begin
            fr_len_acc = fr_len_acc | (24'(b) << (8 * fr_len_idx));
          end
          fr_len_idx  = fr_len_idx + 2'd1;
          fr_len_left = fr_len_left - 2'd1;
          if (fr_len_left == 0) begin
            if (fr_len_acc >= fr_limit) begin
              r.error_code = g2pd_pkg::ERR_LIMIT;
              fr_halted    = 1'b1;
            end else begin
              fr_pay_left  = fr_len_acc;
              fr_type_left = fr_held_count;
              fr_phase     = g2pd_pkg::PH_TYPE;
            end
          end
        end
        g2pd_pkg::PH_TYPE: begin
          r.byte_role  = g2pd_pkg::ROLE_TYPE;
          fr_type_left = fr_type_left - 4'd1;
          if (fr_type_left == 0) begin
            if (fr_pay_left == 0) begin
              r.packet_end = 1'b1;
              fr_phase     = g2pd_pkg::PH_CTRL;
            end else begin
              fr_phase = g2pd_pkg::PH_PAY;
            end
          end
        end
        g2pd_pkg::PH_PAY: begin
          r.byte_role = g2pd_pkg::ROLE_PAY;
          fr_pay_left = fr_pay_left - 24'd1;
          if (fr_pay_left == 0) begin
            r.packet_end = 1'b1;
            fr_phase     = g2pd_pkg::PH_CTRL;
          end
        end
        default: begin
          if (b != 0) begin
            r.byte_role   = g2pd_pkg::ROLE_CTRL;
            fr_held_flags = 3'(b & g2pd_pkg::CTRL_FLAGS_MASK);
            fr_held_count = 4'((b & g2pd_pkg::CTRL_TYPE_MASK) >> 3) + 4'd1;
            fr_len_acc    = '0;
            fr_len_idx    = '0;
            fr_len_left   = 2'((b & g2pd_pkg::CTRL_LENLEN_MASK) >> 6);
            if (fr_len_left == 0) begin
              r.error_code = g2pd_pkg::ERR_LENLEN;
              fr_halted    = 1'b1;
            end else begin
              fr_phase = g2pd_pkg::PH_LEN;
            end
          end
        end
      endcase
    end
    r.packet_flags    = fr_held_flags;
    r.type_byte_count = fr_held_count;
    r.payload_length  = fr_len_acc;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    g2pd_pkg::res_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      pending_tags.push_back(deframe_byte(in_stream_byte));
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_tags.size() == 0) begin
        $display("%0t: byte expected none, got %0h", $time, out_byte_out);
        mismatches++;
      end else begin
        want = pending_tags.pop_front();
        check_field("byte_out", want.byte_out, out_byte_out);
        check_field("byte_role", want.byte_role, out_byte_role);
        check_field("packet_flags", want.packet_flags, out_packet_flags);
        check_field("type_byte_count", want.type_byte_count, out_type_byte_count);
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("packet_end", want.packet_end, out_packet_end);
        check_field("error_code", want.error_code, out_error_code);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 150);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_hold[1:0] == 2'd0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fr_limit = value;
  endtask

  task automatic send_packet(input logic [1:0] lenlen, input logic [2:0] tcode,
                             input logic [2:0] flags, input logic [23:0] len);
    int n;
    int k;
    n = lenlen;
    send_byte({lenlen, tcode, flags});
    for (k = 0; k < n; k++) begin
      if ((flags & g2pd_pkg::FLAG_BIG_ENDIAN) != 0) send_byte(len[8 * (n - 1 - k) +: 8]);
      else send_byte(len[8 * k +: 8]);
    end
    repeat (int'(tcode) + 1) send_byte(8'($urandom));
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_random_packet();
    int ll;
    int cap;
    int len;
    ll  = $urandom_range(1, 3);
    cap = (1 << (8 * ll)) - 1;
    if (cap > int'(fr_limit) - 1) cap = int'(fr_limit) - 1;
    if (cap > 64) cap = 64;
    case ($urandom_range(0, 15))
      0: len = cap;
      1: len = $urandom_range(0, cap);
      default: len = $urandom_range(0, (cap < 12) ? cap : 12);
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(8'h00);
    send_packet(2'(ll), 3'($urandom), 3'($urandom), 24'(len));
  endtask

  task automatic test_framing_basics();
    send_byte(8'h00);
    send_packet(2'd1, 3'd0, 3'd7, 24'd2);
    send_packet(2'd1, 3'd7, 3'd0, 24'd0);
    send_packet(2'd2, 3'd0, g2pd_pkg::FLAG_BIG_ENDIAN, 24'd1);
    send_packet(2'd3, 3'd0, 3'd0, 24'd1);
  endtask

  task automatic test_empty_payload_limit();
    int unsigned start;
    write_limit(24'd1);
    start = sent_items;
    while (sent_items - start < 100) send_random_packet();
  endtask

  task automatic test_wide_limit();
    int unsigned start;
    write_limit(24'hFFFFFF);
    send_packet(2'd2, 3'd0, 3'd0, 24'h000102);
    send_packet(2'd3, 3'd1, g2pd_pkg::FLAG_BIG_ENDIAN, 24'h000005);
    start = sent_items;
    while (sent_items - start < 120) send_random_packet();
  endtask

  task automatic test_random_limit();
    int unsigned start;
    repeat (2) begin
      write_limit(24'($urandom_range(2, 300)));
      start = sent_items;
      while (sent_items - start < 100) send_random_packet();
    end
  endtask

  task automatic test_fatal_error();
    fatal_kind_t kind;
    int ll;
    kind = fatal_kind_t'($urandom_range(0, 2));
    case (kind)
      KILL_LENLEN: begin
        send_byte({2'b00, 6'($urandom_range(1, 63))});
      end
      KILL_MAX_LEN: begin
        write_limit(24'hFFFFFF);
        send_byte({2'b11, 6'($urandom)});
        repeat (3) send_byte(8'hFF);
      end
      default: begin
        write_limit(24'h000000);
        ll = $urandom_range(1, 3);
        send_byte({2'(ll), 6'($urandom)});
        repeat (ll) send_byte(8'($urandom));
      end
    endcase
    repeat (40) send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
  endtask

  initial begin
    reset_deframer_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_framing_basics();
    test_empty_payload_limit();
    test_wide_limit();
    test_random_limit();
    test_fatal_error();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* g2_packet_deframer.f */
+incdir+rtl/core
rtl/core/g2pd_pkg.sv
rtl/core/g2pd_parse.sv
rtl/core/g2pd_rbuf.sv
rtl/core/g2_packet_deframer.sv
rtl/core/g2pd_check.sv
tb/tb_g2_packet_deframer.sv
